### rtl/trimmed_mean_slew_limit_filter_top_macros.svh
// assertion macros for the trimmed mean slew limit filter
// used by the top level, which provides i_clk and i_rst_n
`ifndef TRIMMED_MEAN_SLEW_LIMIT_FILTER_TOP_MACROS_SVH
`define TRIMMED_MEAN_SLEW_LIMIT_FILTER_TOP_MACROS_SVH

// same-cycle implication under reset
`define TMSLF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define TMSLF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tmslf_pkg.sv
// shared types and constants for the trimmed mean slew limit filter
// no dependencies
`default_nettype none

package tmslf_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_SETTLE,
        S_DRAIN,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    // control shared by every sorting cell
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

    // register indexes
    localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
    localparam logic [1:0] REG_TRIM_COUNT    = 2'd1;
    localparam logic [1:0] REG_MAX_AMPLITUDE = 2'd2;
    localparam logic [1:0] REG_MAX_SLOPE     = 2'd3;

    // register widths and reset values
    localparam int unsigned WS_W  = 6;
    localparam int unsigned TC_W  = 5;
    localparam int unsigned LIM_W = 23;
    localparam logic [WS_W-1:0]  WS_RESET  = 6'd10;
    localparam logic [TC_W-1:0]  TC_RESET  = 5'd2;
    localparam logic [LIM_W-1:0] AMP_RESET = 23'd128000;
    localparam logic [LIM_W-1:0] SLP_RESET = 23'd7680;

    // smallest usable window
    localparam int unsigned MIN_WIN = 3;

endpackage

`default_nettype wire

### rtl/trimmed_mean_slew_limit_filter_top.sv
// Trimmed mean filter with amplitude hold and slew limit. Each item is written
// into a ring window held in a local memory. Until the window fills once the
// sample is passed through. After that the window is read out one entry a cycle
// into a chain of MAX_WINDOW sorting cells, left to settle, shifted out with the
// trimmed entries summed, divided by a one-bit-per-cycle divider, then checked
// against the amplitude and slope limits. One item is worked at a time; the next
// is taken once the result has moved to the output register.
`default_nettype none

`include "trimmed_mean_slew_limit_filter_top_macros.svh"

module trimmed_mean_slew_limit_filter_top #(
    parameter int unsigned MAX_WINDOW   = 32,
    parameter int unsigned SAMPLE_WIDTH = 24
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [3:0]                      paddr,
    input  wire  [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input items
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire signed [SAMPLE_WIDTH-1:0]   i_sample,
    // result items
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]  o_filtered,
    output logic                            o_warming_up,
    output logic                            o_amplitude_held,
    output logic                            o_slope_limited
);
    import tmslf_pkg::*;

    localparam int unsigned AW    = $clog2(MAX_WINDOW);
    localparam int unsigned WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int unsigned CW    = (WIN_W > WS_W) ? WIN_W + 1 : WS_W + 1;
    localparam int unsigned SUM_W = SAMPLE_WIDTH + WIN_W + 1;
    localparam int unsigned CTR_W = $clog2(SUM_W + MAX_WINDOW + 2);
    localparam int unsigned EW    = ((SAMPLE_WIDTH > LIM_W) ? SAMPLE_WIDTH : LIM_W) + 2;

    // configuration registers
    logic [WS_W-1:0]  r_window_size;
    logic [TC_W-1:0]  r_trim_count;
    logic [LIM_W-1:0] r_max_amplitude;
    logic [LIM_W-1:0] r_max_slope;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size   <= WS_RESET;
            r_trim_count    <= TC_RESET;
            r_max_amplitude <= AMP_RESET;
            r_max_slope     <= SLP_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_WINDOW_SIZE:   r_window_size   <= pwdata[WS_W-1:0];
                REG_TRIM_COUNT:    r_trim_count    <= pwdata[TC_W-1:0];
                REG_MAX_AMPLITUDE: r_max_amplitude <= pwdata[LIM_W-1:0];
                REG_MAX_SLOPE:     r_max_slope     <= pwdata[LIM_W-1:0];
                default:           r_max_slope     <= r_max_slope;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_WINDOW_SIZE:   prdata = 32'(r_window_size);
            REG_TRIM_COUNT:    prdata = 32'(r_trim_count);
            REG_MAX_AMPLITUDE: prdata = 32'(r_max_amplitude);
            REG_MAX_SLOPE:     prdata = 32'(r_max_slope);
            default:           prdata = '0;
        endcase
    end

    // window length, trim and kept count
    logic [CW-1:0]    ws_x;
    logic [CW-1:0]    w_x;
    logic [WIN_W-1:0] win;
    logic [WIN_W-1:0] trim;
    logic [WIN_W-1:0] keep;

    always_comb begin
        ws_x = CW'(r_window_size);
        if (ws_x > CW'(MAX_WINDOW)) begin
            w_x = CW'(MAX_WINDOW);
        end else if (ws_x < CW'(MIN_WIN)) begin
            w_x = CW'(MIN_WIN);
        end else begin
            w_x = ws_x;
        end
        win = WIN_W'(w_x);
        if (CW'(r_trim_count) >= (w_x >> 1)) begin
            trim = WIN_W'(1);
        end else begin
            trim = WIN_W'(r_trim_count);
        end
        keep = win - (trim << 1);
    end

    // sequencer registers
    t_state                          r_state, n_state;
    logic [CTR_W-1:0]                r_cnt;
    logic [AW-1:0]                   r_pos;
    logic                            r_full;
    logic signed [SAMPLE_WIDTH-1:0]  r_last;
    logic signed [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]                r_quo;
    logic [WIN_W:0]                  r_rem;
    logic                            r_neg;
    logic signed [SAMPLE_WIDTH-1:0]  r_res_val;
    logic                            r_res_warm;
    logic                            r_res_held;
    logic                            r_res_lim;

    logic in_acc;
    logic out_free;
    assign in_acc   = i_in_valid & ~o_in_stall;
    assign out_free = ~o_out_valid | ~i_out_stall;

    // ring position after this item
    logic [WIN_W-1:0] pos_inc;
    logic             pos_wrap;
    assign pos_inc  = WIN_W'(r_pos) + WIN_W'(1);
    assign pos_wrap = (pos_inc >= win);

    // history memory
    logic signed [SAMPLE_WIDTH-1:0] mem [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] r_rd;
    logic                           r_rd_vld;
    logic                           rd_en;
    assign rd_en = (r_state == S_FEED) && (r_cnt < CTR_W'(win));

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem[r_pos] <= i_sample;
        end
        r_rd <= mem[r_cnt[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
        end
    end

    // sorting chain
    t_cell_ctrl                     cell_ctrl;
    logic                           ch_vld [MAX_WINDOW+1];
    logic signed [SAMPLE_WIDTH-1:0] ch_val [MAX_WINDOW+1];
    logic signed [SAMPLE_WIDTH-1:0] cell_v [MAX_WINDOW+1];

    assign cell_ctrl.clear = in_acc;
    assign cell_ctrl.shift = (r_state == S_DRAIN);
    assign ch_vld[0] = r_rd_vld;
    assign ch_val[0] = r_rd;
    assign cell_v[MAX_WINDOW] = '0;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        tmslf_cell #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (cell_ctrl),
            .i_ins_vld (ch_vld[g]),
            .i_ins_val (ch_val[g]),
            .i_shf_val (cell_v[g+1]),
            .o_ins_vld (ch_vld[g+1]),
            .o_ins_val (ch_val[g+1]),
            .o_val     (cell_v[g])
        );
    end

    // divider step
    logic [WIN_W:0] rem_sh;
    logic           rem_ge;
    assign rem_sh = {r_rem[WIN_W-1:0], r_quo[SUM_W-1]};
    assign rem_ge = (rem_sh >= (WIN_W+1)'(keep));

    // final checks on the average
    logic signed [EW-1:0] avg, avg_abs, last_x, diff, diff_abs, lim, lim_sat;
    logic signed [EW-1:0] amp_x, slp_x;
    logic                 held, limited;
    logic signed [SAMPLE_WIDTH-1:0] fin_val;

    always_comb begin
        avg      = r_neg ? -EW'($signed({1'b0, r_quo})) : EW'($signed({1'b0, r_quo}));
        avg_abs  = (avg < 0) ? -avg : avg;
        last_x   = EW'(r_last);
        amp_x    = EW'($signed({1'b0, r_max_amplitude}));
        slp_x    = EW'($signed({1'b0, r_max_slope}));
        diff     = avg - last_x;
        diff_abs = (diff < 0) ? -diff : diff;
        lim      = (avg > last_x) ? last_x + slp_x : last_x - slp_x;
        if (lim > EW'(r_last) && lim > $signed(EW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}))) begin
            lim_sat = $signed(EW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}));
        end else if (lim < -$signed(EW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}})) - EW'(1)) begin
            lim_sat = -$signed(EW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}})) - EW'(1);
        end else begin
            lim_sat = lim;
        end
        held    = (avg_abs > amp_x);
        limited = !held && (diff_abs > slp_x);
        if (held) begin
            fin_val = r_last;
        end else if (limited) begin
            fin_val = SAMPLE_WIDTH'(lim_sat);
        end else begin
            fin_val = SAMPLE_WIDTH'(avg);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_acc) n_state = (pos_wrap || r_full) ? S_FEED : S_OUT;
            S_FEED:   if (r_cnt == CTR_W'(win)) n_state = S_SETTLE;
            S_SETTLE: if (r_cnt == CTR_W'(MAX_WINDOW + 1)) n_state = S_DRAIN;
            S_DRAIN:  if (r_cnt == CTR_W'(win)) n_state = S_DIV;
            S_DIV:    if (r_cnt == CTR_W'(SUM_W - 1)) n_state = S_FIN;
            S_FIN:    n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_full  <= 1'b0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + CTR_W'(1);
            end
            if (in_acc) begin
                r_pos <= pos_wrap ? '0 : AW'(pos_inc);
                if (pos_wrap) begin
                    r_full <= 1'b1;
                end
                if (!(pos_wrap || r_full)) begin
                    r_last <= i_sample;
                end
            end
            if (r_state == S_FIN) begin
                r_last <= fin_val;
            end
        end
    end

    // datapath: trimmed sum, division, result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sum      <= '0;
            r_res_val  <= i_sample;
            r_res_warm <= 1'b1;
            r_res_held <= 1'b0;
            r_res_lim  <= 1'b0;
        end
        if (r_state == S_DRAIN) begin
            if (r_cnt >= CTR_W'(trim) && r_cnt < CTR_W'(win - trim)) begin
                r_sum <= r_sum + SUM_W'(cell_v[0]);
            end
            if (r_cnt == CTR_W'(win)) begin
                r_neg <= r_sum[SUM_W-1];
                r_quo <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                r_rem <= '0;
            end
        end
        if (r_state == S_DIV) begin
            r_rem <= rem_ge ? rem_sh - (WIN_W+1)'(keep) : rem_sh;
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
        end
        if (r_state == S_FIN) begin
            r_res_val  <= fin_val;
            r_res_warm <= 1'b0;
            r_res_held <= held;
            r_res_lim  <= limited;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            o_filtered       <= r_res_val;
            o_warming_up     <= r_res_warm;
            o_amplitude_held <= r_res_held;
            o_slope_limited  <= r_res_lim;
        end
    end

    // checks
    `TMSLF_ASSERT_NEXT(a_busy_after_accept, in_acc, o_in_stall,
        "input not stalled after an item was accepted")
    `TMSLF_ASSERT_NOW(a_flags_exclusive, o_out_valid,
        !(o_amplitude_held && o_slope_limited),
        "amplitude hold and slope limit both set")
    `TMSLF_ASSERT_NOW(a_warm_clean, o_out_valid && o_warming_up,
        !o_amplitude_held && !o_slope_limited,
        "warm-up result carries limit flags")
    `TMSLF_ASSERT_NEXT(a_fin_to_out, r_state == S_FIN, r_state == S_OUT,
        "result not presented after final step")

endmodule

`default_nettype wire

### rtl/tmslf_cell.sv
// one cell of the systolic insertion sorter
// depends on tmslf_pkg
`default_nettype none

module tmslf_cell #(
    parameter int unsigned SAMPLE_WIDTH = 24
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire tmslf_pkg::t_cell_ctrl      i_ctrl,
    input  wire                             i_ins_vld,
    input  wire signed [SAMPLE_WIDTH-1:0]   i_ins_val,
    input  wire signed [SAMPLE_WIDTH-1:0]   i_shf_val,
    output logic                            o_ins_vld,
    output logic signed [SAMPLE_WIDTH-1:0]  o_ins_val,
    output logic signed [SAMPLE_WIDTH-1:0]  o_val
);
    import tmslf_pkg::*;

    logic                           r_full;
    logic signed [SAMPLE_WIDTH-1:0] r_val;
    logic                           r_out_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_out_val;

    // control: occupancy and pass-on valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_full    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_out_vld <= 1'b0;
        end else if (i_ins_vld) begin
            r_full    <= 1'b1;
            r_out_vld <= r_full;
        end else begin
            r_out_vld <= 1'b0;
        end
    end

    // payload: keep the smaller value, pass the larger one right; on shift take the right neighbour's value
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_val <= i_shf_val;
        end else if (i_ins_vld) begin
            if (!r_full) begin
                r_val <= i_ins_val;
            end else if (i_ins_val < r_val) begin
                r_val     <= i_ins_val;
                r_out_val <= r_val;
            end else begin
                r_out_val <= i_ins_val;
            end
        end
    end

    assign o_ins_vld = r_out_vld;
    assign o_ins_val = r_out_val;
    assign o_val     = r_val;

endmodule

`default_nettype wire
